[hdl/twi_transaction_sequencer_macros.svh]
// assertion macros shared by the twi transaction sequencer rtl
// expects a signal named clock and a signal named reset in the using scope
`ifndef TWI_TRANSACTION_SEQUENCER_MACROS_SVH
`define TWI_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication, held off during reset
`define TWI_SEQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define TWI_SEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/twi_seq_pkg.sv]
// types, codes and field widths of the twi transaction sequencer
// no dependencies
package twi_seq_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 5;
   localparam int EV_W   = 5;
   localparam int RXP_W  = 4;

   localparam int DEFAULT_TX_DEPTH = 16;
   localparam int DEFAULT_RX_DEPTH = 16;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_EVENT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_BYTE  = 3'd3,
      ACT_ACK   = 3'd4,
      ACT_NACK  = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      MODE_READY = 3'd0,
      MODE_INIT  = 3'd1,
      MODE_MT    = 3'd2,
      MODE_MR    = 3'd3,
      MODE_REP   = 3'd4,
      MODE_SR    = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      OUT_NONE     = 2'd0,
      OUT_SUCCESS  = 2'd1,
      OUT_FAILED   = 2'd2,
      OUT_REJECTED = 2'd3
   } outcome_type;

   typedef enum logic [4:0] {
      EV_MT_SLA_ACK         = 5'd0,
      EV_START              = 5'd1,
      EV_MT_DATA_ACK        = 5'd2,
      EV_MR_SLA_ACK         = 5'd3,
      EV_MR_DATA_ACK        = 5'd4,
      EV_MR_DATA_NACK       = 5'd5,
      EV_MR_SLA_NACK        = 5'd6,
      EV_MT_SLA_NACK        = 5'd7,
      EV_MT_DATA_NACK       = 5'd8,
      EV_ARB_LOST           = 5'd9,
      EV_REP_START          = 5'd10,
      EV_SR_GCALL_ACK       = 5'd11,
      EV_SR_SLA_ACK         = 5'd12,
      EV_SR_GCALL_DATA_ACK  = 5'd13,
      EV_SR_DATA_ACK        = 5'd14,
      EV_SR_GCALL_DATA_NACK = 5'd15,
      EV_SR_DATA_NACK       = 5'd16,
      EV_SR_STOP            = 5'd17,
      EV_ST_ARB_LOST        = 5'd18,
      EV_SR_ARB_LOST        = 5'd19,
      EV_SR_GCALL_ARB_LOST  = 5'd20,
      EV_SUCCESS            = 5'd21,
      EV_NO_INFO            = 5'd22,
      EV_BUS_ERROR          = 5'd23
   } event_type;

   // result of one step, before the store read data is merged in
   typedef struct packed {
      action_type          act;
      logic                need_read;
      logic                rx_valid;
      logic [DATA_W-1:0]   rx_byte;
      logic [RXP_W-1:0]    rx_position;
      mode_type            mode;
      outcome_type         outcome;
      logic [EV_W-1:0]     fail_event;
   } step_type;

endpackage

[hdl/twi_seq_store.sv]
// transmit byte store: one write port, one registered read port
// same-address write and read in one cycle returns the new byte
module twi_seq_store #(
   parameter int TX_DEPTH = twi_seq_pkg::DEFAULT_TX_DEPTH,
   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [twi_seq_pkg::DATA_W-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [twi_seq_pkg::DATA_W-1:0] rd_data
);

   logic [twi_seq_pkg::DATA_W-1:0] mem [TX_DEPTH];
   logic [twi_seq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/twi_seq_ctrl.sv]
// transaction state and next-step logic of the twi sequencer
// uses twi_seq_pkg; drives the transmit store write and read ports
module twi_seq_ctrl #(
   parameter int TX_DEPTH = twi_seq_pkg::DEFAULT_TX_DEPTH,
   parameter int RX_DEPTH = twi_seq_pkg::DEFAULT_RX_DEPTH,
   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     command,
   input  logic [twi_seq_pkg::DATA_W-1:0] data,
   input  logic [twi_seq_pkg::LEN_W-1:0]  length,
   input  logic                           want_repeated_start,
   input  logic [twi_seq_pkg::EV_W-1:0]   bus_event,
   output twi_seq_pkg::step_type          step,
   output logic                           mem_wr_en,
   output logic [AW-1:0]                  mem_wr_addr,
   output logic [twi_seq_pkg::DATA_W-1:0] mem_wr_data,
   output logic                           mem_rd_en,
   output logic [AW-1:0]                  mem_rd_addr
);

   localparam int FW  = $clog2(TX_DEPTH + 1);
   localparam int RPW = $clog2(RX_DEPTH + 1);

   logic [twi_seq_pkg::LEN_W-1:0] tx_position_ff, tx_position_in;
   logic [twi_seq_pkg::LEN_W-1:0] tx_count_ff, tx_count_in;
   logic [FW-1:0]                 fill_ff, fill_in;
   logic [RPW-1:0]                rx_pos_ff, rx_pos_in;
   logic [twi_seq_pkg::LEN_W-1:0] rx_count_ff, rx_count_in;
   twi_seq_pkg::mode_type         mode_ff, mode_in;
   logic                          repeat_ff, repeat_in;
   logic [twi_seq_pkg::EV_W-1:0]  last_code_ff, last_code_in;

   twi_seq_pkg::step_type         st;
   logic                          is_ready;
   logic                          wr_en;
   logic [AW-1:0]                 rd_addr;
   logic                          do_begin;
   logic [twi_seq_pkg::LEN_W-1:0] begin_len;
   logic                          do_finish;
   logic                          fin_failed;
   logic                          do_deliver;
   logic                          do_send;

   always_comb begin
      st             = '0;
      st.act         = twi_seq_pkg::ACT_NONE;
      st.outcome     = twi_seq_pkg::OUT_NONE;
      tx_position_in = tx_position_ff;
      tx_count_in    = tx_count_ff;
      fill_in        = fill_ff;
      rx_pos_in      = rx_pos_ff;
      rx_count_in    = rx_count_ff;
      mode_in        = mode_ff;
      repeat_in      = repeat_ff;
      last_code_in   = last_code_ff;
      is_ready       = (mode_ff == twi_seq_pkg::MODE_READY) ||
                       (mode_ff == twi_seq_pkg::MODE_REP);
      wr_en          = 1'b0;
      mem_wr_addr    = AW'(fill_ff);
      mem_wr_data    = data;
      rd_addr        = '0;
      do_begin       = 1'b0;
      begin_len      = length;
      do_finish      = 1'b0;
      fin_failed     = 1'b0;
      do_deliver     = 1'b0;
      do_send        = 1'b0;

      case (command)
         twi_seq_pkg::CMD_PUSH: begin
            if (is_ready && (32'(fill_ff) < TX_DEPTH)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + FW'(1);
            end else begin
               st.outcome = twi_seq_pkg::OUT_REJECTED;
            end
         end
         twi_seq_pkg::CMD_WRITE: begin
            if (is_ready && (32'(length) <= TX_DEPTH)) begin
               do_begin = 1'b1;
            end else begin
               st.outcome = twi_seq_pkg::OUT_REJECTED;
            end
         end
         twi_seq_pkg::CMD_READ: begin
            if (is_ready && (32'(length) < RX_DEPTH)) begin
               rx_pos_in   = '0;
               rx_count_in = length;
               wr_en       = 1'b1;
               mem_wr_addr = '0;
               mem_wr_data = {data[twi_seq_pkg::DATA_W-2:0], 1'b1};
               do_begin    = 1'b1;
               begin_len   = twi_seq_pkg::LEN_W'(1);
            end else begin
               st.outcome = twi_seq_pkg::OUT_REJECTED;
            end
         end
         twi_seq_pkg::CMD_EVENT: begin
            case (bus_event)
               twi_seq_pkg::EV_MT_SLA_ACK: begin
                  mode_in = twi_seq_pkg::MODE_MT;
                  do_send = 1'b1;
               end
               twi_seq_pkg::EV_START, twi_seq_pkg::EV_MT_DATA_ACK: begin
                  do_send = 1'b1;
               end
               twi_seq_pkg::EV_MR_SLA_ACK: begin
                  mode_in = twi_seq_pkg::MODE_MR;
               end
               twi_seq_pkg::EV_MR_DATA_ACK,
               twi_seq_pkg::EV_SR_GCALL_DATA_ACK, twi_seq_pkg::EV_SR_DATA_ACK: begin
                  do_deliver = 1'b1;
               end
               twi_seq_pkg::EV_MR_DATA_NACK, twi_seq_pkg::EV_SR_GCALL_DATA_NACK,
               twi_seq_pkg::EV_SR_DATA_NACK: begin
                  do_deliver = 1'b1;
                  do_finish  = 1'b1;
               end
               twi_seq_pkg::EV_MR_SLA_NACK, twi_seq_pkg::EV_MT_SLA_NACK,
               twi_seq_pkg::EV_MT_DATA_NACK, twi_seq_pkg::EV_ARB_LOST: begin
                  do_finish  = 1'b1;
                  fin_failed = 1'b1;
               end
               twi_seq_pkg::EV_REP_START: begin
                  mode_in = twi_seq_pkg::MODE_REP;
               end
               twi_seq_pkg::EV_SR_GCALL_ACK, twi_seq_pkg::EV_SR_SLA_ACK: begin
                  mode_in = twi_seq_pkg::MODE_SR;
               end
               twi_seq_pkg::EV_SR_STOP, twi_seq_pkg::EV_ST_ARB_LOST,
               twi_seq_pkg::EV_SR_ARB_LOST, twi_seq_pkg::EV_SR_GCALL_ARB_LOST: begin
                  st.act = twi_seq_pkg::ACT_NACK;
               end
               twi_seq_pkg::EV_BUS_ERROR: begin
                  mode_in = twi_seq_pkg::MODE_READY;
                  st.act  = twi_seq_pkg::ACT_STOP;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      // received byte, dropped once the receive window is full
      if (do_deliver && (32'(rx_pos_ff) < RX_DEPTH)) begin
         st.rx_valid    = 1'b1;
         st.rx_byte     = data;
         st.rx_position = twi_seq_pkg::RXP_W'(rx_pos_ff);
         rx_pos_in      = rx_pos_ff + RPW'(1);
      end

      // ack decisions look at the position after delivery
      if (command == twi_seq_pkg::CMD_EVENT) begin
         if ((bus_event == twi_seq_pkg::EV_MR_SLA_ACK) ||
             (bus_event == twi_seq_pkg::EV_MR_DATA_ACK)) begin
            st.act = ((32'(rx_pos_in) + 32'd1) < 32'(rx_count_ff)) ?
                     twi_seq_pkg::ACT_ACK : twi_seq_pkg::ACT_NACK;
         end
         if ((bus_event == twi_seq_pkg::EV_SR_GCALL_ACK) ||
             (bus_event == twi_seq_pkg::EV_SR_SLA_ACK) ||
             (bus_event == twi_seq_pkg::EV_SR_GCALL_DATA_ACK) ||
             (bus_event == twi_seq_pkg::EV_SR_DATA_ACK)) begin
            st.act = (32'(rx_pos_in) < 32'(rx_count_ff)) ?
                     twi_seq_pkg::ACT_ACK : twi_seq_pkg::ACT_NACK;
         end
      end

      if (do_send) begin
         if ((tx_position_ff < tx_count_ff) && (32'(tx_position_ff) < TX_DEPTH)) begin
            st.act         = twi_seq_pkg::ACT_BYTE;
            st.need_read   = 1'b1;
            rd_addr        = AW'(tx_position_ff);
            tx_position_in = tx_position_ff + twi_seq_pkg::LEN_W'(1);
         end else begin
            do_finish = 1'b1;
         end
      end

      if (do_finish) begin
         st.outcome = fin_failed ? twi_seq_pkg::OUT_FAILED : twi_seq_pkg::OUT_SUCCESS;
         if (fin_failed) begin
            last_code_in  = bus_event;
            st.fail_event = bus_event;
         end
         if (repeat_ff) begin
            st.act = twi_seq_pkg::ACT_START;
         end else begin
            mode_in = twi_seq_pkg::MODE_READY;
            st.act  = twi_seq_pkg::ACT_STOP;
         end
      end

      if (do_begin) begin
         tx_count_in = begin_len;
         fill_in     = '0;
         repeat_in   = want_repeated_start;
         if (mode_ff == twi_seq_pkg::MODE_REP) begin
            st.act         = twi_seq_pkg::ACT_BYTE;
            st.need_read   = 1'b1;
            rd_addr        = '0;
            tx_position_in = twi_seq_pkg::LEN_W'(1);
         end else begin
            st.act         = twi_seq_pkg::ACT_START;
            tx_position_in = '0;
         end
         mode_in = twi_seq_pkg::MODE_INIT;
      end

      st.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_position_ff <= '0;
         tx_count_ff    <= '0;
         fill_ff        <= '0;
         rx_pos_ff      <= '0;
         rx_count_ff    <= '0;
         mode_ff        <= twi_seq_pkg::MODE_READY;
         repeat_ff      <= 1'b0;
         last_code_ff   <= '0;
      end else if (accept) begin
         tx_position_ff <= tx_position_in;
         tx_count_ff    <= tx_count_in;
         fill_ff        <= fill_in;
         rx_pos_ff      <= rx_pos_in;
         rx_count_ff    <= rx_count_in;
         mode_ff        <= mode_in;
         repeat_ff      <= repeat_in;
         last_code_ff   <= last_code_in;
      end
   end

   assign step        = st;
   assign mem_wr_en   = accept && wr_en;
   assign mem_rd_en   = accept && st.need_read;
   assign mem_rd_addr = rd_addr;

endmodule

[hdl/twi_transaction_sequencer.sv]
// top level of the twi transaction sequencer: handshake pipeline and result register
// uses twi_seq_pkg, twi_seq_ctrl, twi_seq_store and the assertion macro header
//
// usage
//   req channel: one transaction per host command or bus status event;
//     req_tuser carries the command, req_tdata the data, length, repeat flag
//     and event code
//   rsp channel: exactly one transaction per accepted request, in order,
//     carrying the next bus action, any received byte and the status
//   pipeline: an accepted request passes the read stage, then the result register
//   throughput: one request per cycle while results are taken; the transaction
//     state is updated in the accept cycle and the transmit store read completes
//     in the next cycle, so results overlap with the following requests
//   stall: when rsp_tready is low the result holds, one more step waits in the
//     read stage and req_tready then drops until the result is taken
//   reset: synchronous; mode returns to ready, indices and counts clear, both
//     channels empty; transmit store contents are unknown until pushed
//
`include "twi_transaction_sequencer_macros.svh"

module twi_transaction_sequencer #(
   parameter int TX_DEPTH = twi_seq_pkg::DEFAULT_TX_DEPTH,
   parameter int RX_DEPTH = twi_seq_pkg::DEFAULT_RX_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data, [12:8] length, [13] want_repeated_start, [18:14] bus_event
   input  logic [23:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tx_byte, [8] rx_valid, [16:9] rx_byte, [20:17] rx_position,
   // [23:21] mode, [24] ready_res, [26:25] outcome, [31:27] fail_event
   output logic [31:0] rsp_tdata,
   // [2:0] bus_action
   output logic [2:0]  rsp_tuser
);

   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   logic                           accept;
   logic                           p_move;
   twi_seq_pkg::step_type          step;
   logic                           mem_wr_en;
   logic [AW-1:0]                  mem_wr_addr;
   logic [twi_seq_pkg::DATA_W-1:0] mem_wr_data;
   logic                           mem_rd_en;
   logic [AW-1:0]                  mem_rd_addr;
   logic [twi_seq_pkg::DATA_W-1:0] mem_rd_data;

   logic                           p_valid_ff;
   twi_seq_pkg::step_type          p_step_ff;
   logic                           rsp_valid_ff;
   logic [31:0]                    rsp_data_ff;
   logic [2:0]                     rsp_user_ff;

   logic [twi_seq_pkg::DATA_W-1:0] tx_byte;
   logic                           ready_res;
   logic [31:0]                    rsp_data_in;

   assign p_move     = p_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !p_valid_ff || p_move;
   assign accept     = req_tvalid && req_tready;

   twi_seq_ctrl #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .command             (req_tuser),
      .data                (req_tdata[7:0]),
      .length              (req_tdata[12:8]),
      .want_repeated_start (req_tdata[13]),
      .bus_event           (req_tdata[18:14]),
      .step                (step),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr)
   );

   twi_seq_store #(
      .TX_DEPTH (TX_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      tx_byte     = p_step_ff.need_read ? mem_rd_data : '0;
      ready_res   = (p_step_ff.mode == twi_seq_pkg::MODE_READY) ||
                    (p_step_ff.mode == twi_seq_pkg::MODE_REP);
      rsp_data_in = {p_step_ff.fail_event, p_step_ff.outcome, ready_res,
                     p_step_ff.mode, p_step_ff.rx_position, p_step_ff.rx_byte,
                     p_step_ff.rx_valid, tx_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (accept) begin
         p_valid_ff <= 1'b1;
      end else if (p_move) begin
         p_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_step_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (p_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (p_move) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= p_step_ff.act;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `TWI_SEQ_ASSERT_NEXT(a_accept_fills_stage, accept, p_valid_ff,
      "accepted request missing from read stage")
   `TWI_SEQ_ASSERT_NOW(a_fail_has_code,
      rsp_valid_ff && (rsp_data_ff[26:25] == twi_seq_pkg::OUT_FAILED),
      rsp_data_ff[31:27] != 5'd0, "failure reported without event code")
   `TWI_SEQ_ASSERT_NOW(a_rx_not_byte, rsp_valid_ff && rsp_data_ff[8],
      rsp_user_ff != twi_seq_pkg::ACT_BYTE, "received byte paired with send byte")
   `TWI_SEQ_ASSERT_NOW(a_read_only_on_accept, mem_rd_en, accept,
      "store read issued without an accepted request")

endmodule
